### hdl/ste_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ste_pkg
// Shared codes, port widths and controller/datapath interface types for the
// sorted table engine.
// ----------------------------------------------------------------------------
package ste_pkg;

   localparam int DEF_CAPACITY  = 32;
   localparam int DEF_KEY_WIDTH = 32;

   localparam int ACTION_W     = 3;
   localparam int KEY_PORT_W   = 32;
   localparam int STATUS_W     = 2;
   localparam int INDEX_PORT_W = 5;
   localparam int COUNT_PORT_W = 6;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REM_MIN = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REM_MAX = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SEARCH  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd4;

   // result status
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // read port a address select
   localparam logic [1:0] RD_ENDS = 2'd0;
   localparam logic [1:0] RD_PREV = 2'd1;
   localparam logic [1:0] RD_NEXT = 2'd2;
   localparam logic [1:0] RD_MID  = 2'd3;

   typedef struct packed {
      logic                capture;
      logic [STATUS_W-1:0] status;
      logic                idx_ins;
      logic                idx_rm;
      logic                idx_dec;
      logic                idx_inc;
      logic [1:0]          rd_sel;
      logic                wr_en;
      logic                wr_key;
      logic                srch_init;
      logic                srch_probe;
      logic                srch_left;
      logic                srch_right;
      logic                hit;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                cnt_clr;
      logic                out_load;
   } ste_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic idx_zero;
      logic rd_gt_key;
      logic rd_eq_key;
      logic rm_more;
      logic probe_done;
      logic out_busy;
   } ste_stat_type;

endpackage
`default_nettype wire

### hdl/ste_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ste_datapath
// Key store, count, walk index, search bounds and the result word register.
// ----------------------------------------------------------------------------
module ste_datapath
   import ste_pkg::*;
#(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [KEY_PORT_W-1:0]   req_key,
   input  wire ste_cmd_type             cmd,
   output      ste_stat_type            stat,
   input  wire logic                    rsp_stall,
   output      logic                    rsp_valid,
   output      logic [STATUS_W-1:0]     rsp_status,
   output      logic                    rsp_found,
   output      logic [INDEX_PORT_W-1:0] rsp_found_index,
   output      logic [COUNT_PORT_W-1:0] rsp_count,
   output      logic [KEY_PORT_W-1:0]   rsp_min_key,
   output      logic [KEY_PORT_W-1:0]   rsp_max_key,
   output      logic                    rsp_is_empty
);

   localparam int SW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [SW-1:0] mem [CAPACITY];
   logic [SW-1:0] rd_a_ff, rd_b_ff;
   logic [IW-1:0] raddr_a, raddr_b, waddr;
   logic [SW-1:0] wdata;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [IW-1:0] mid_ff, mid_in;
   logic [SW-1:0] key_ff, key_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic          hit_ff, hit_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] idx_prev, idx_next, cnt_last;
   logic [CW:0]   mid_sum, mid_full;
   logic [IW-1:0] mid_idx;
   logic          empty_now;

   assign idx_prev = idx_ff - CW'(1);
   assign idx_next = idx_ff + CW'(1);
   assign cnt_last = count_ff - CW'(1);
   // lower midpoint of lo..hi-1 (hi is exclusive)
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW+1)'(1);
   assign mid_full = mid_sum >> 1;
   assign mid_idx  = mid_full[IW-1:0];
   assign empty_now = (count_ff == '0);

   always_comb begin
      case (cmd.rd_sel)
         RD_PREV: raddr_a = idx_prev[IW-1:0];
         RD_NEXT: raddr_a = idx_next[IW-1:0];
         RD_MID:  raddr_a = mid_idx;
         default: raddr_a = '0;
      endcase
      raddr_b = cnt_last[IW-1:0];
      waddr   = idx_ff[IW-1:0];
      wdata   = cmd.wr_key ? key_ff : rd_a_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[waddr] <= wdata;
      end
      rd_a_ff <= mem[raddr_a];
      rd_b_ff <= mem[raddr_b];
   end

   always_comb begin
      key_in    = cmd.capture ? req_key[SW-1:0] : key_ff;
      status_in = cmd.capture ? cmd.status : status_ff;
      hit_in    = cmd.capture ? 1'b0 : (hit_ff | cmd.hit);

      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = cnt_last;
      end

      idx_in = idx_ff;
      if (cmd.idx_ins) begin
         idx_in = count_ff;
      end else if (cmd.idx_rm) begin
         idx_in = '0;
      end else if (cmd.idx_dec) begin
         idx_in = idx_prev;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end

      lo_in  = lo_ff;
      hi_in  = hi_ff;
      mid_in = mid_ff;
      if (cmd.capture) begin
         mid_in = '0;
      end
      if (cmd.srch_init) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.srch_probe) begin
         mid_in = mid_idx;
      end
      if (cmd.srch_left) begin
         hi_in = CW'(mid_ff);
      end
      if (cmd.srch_right) begin
         lo_in = CW'(mid_ff) + CW'(1);
      end

      rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

   // result word, held until taken
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status      <= status_ff;
         rsp_found       <= hit_ff;
         rsp_found_index <= hit_ff ? INDEX_PORT_W'(mid_ff) : '0;
         rsp_count       <= COUNT_PORT_W'(count_ff);
         rsp_min_key     <= empty_now ? '0 : KEY_PORT_W'(rd_a_ff);
         rsp_max_key     <= empty_now ? '0 : KEY_PORT_W'(rd_b_ff);
         rsp_is_empty    <= empty_now;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      stat.full       = (count_ff >= CW'(CAPACITY));
      stat.empty      = empty_now;
      stat.idx_zero   = (idx_ff == '0);
      stat.rd_gt_key  = (rd_a_ff > key_ff);
      stat.rd_eq_key  = (rd_a_ff == key_ff);
      stat.rm_more    = (idx_next < count_ff);
      stat.probe_done = (lo_ff >= hi_ff);
      stat.out_busy   = rsp_valid_ff & rsp_stall;
   end

endmodule
`default_nettype wire

### hdl/ste_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ste_control
// Request sequencer: dispatches each action and steps the datapath through
// shifting, searching and the final min/max read.
// ----------------------------------------------------------------------------
module ste_control
   import ste_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire ste_stat_type        stat,
   output      ste_cmd_type         cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INS_RD   = 4'd1;
   localparam logic [3:0] S_INS_CHK  = 4'd2;
   localparam logic [3:0] S_RM_RD    = 4'd3;
   localparam logic [3:0] S_RM_WR    = 4'd4;
   localparam logic [3:0] S_SR_PROBE = 4'd5;
   localparam logic [3:0] S_SR_CHK   = 4'd6;
   localparam logic [3:0] S_FIN      = 4'd7;
   localparam logic [3:0] S_FIN2     = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      cmd.status = ST_DONE;
      cmd.rd_sel = RD_ENDS;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_action)
                  ACT_INSERT: begin
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                        state_in   = S_FIN;
                     end else begin
                        cmd.idx_ins = 1'b1;
                        state_in    = S_INS_RD;
                     end
                  end
                  ACT_REM_MIN: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                        state_in   = S_FIN;
                     end else begin
                        cmd.idx_rm = 1'b1;
                        state_in   = S_RM_RD;
                     end
                  end
                  ACT_REM_MAX: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.cnt_dec = 1'b1;
                     end
                     state_in = S_FIN;
                  end
                  ACT_SEARCH: begin
                     cmd.srch_init = 1'b1;
                     state_in      = S_SR_PROBE;
                  end
                  ACT_CLEAR: begin
                     cmd.cnt_clr = 1'b1;
                     state_in    = S_FIN;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (stat.idx_zero) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_key  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_FIN;
            end else begin
               cmd.rd_sel = RD_PREV;
               state_in   = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            // larger neighbour moves up one place, else the key lands here
            if (stat.rd_gt_key) begin
               cmd.wr_en   = 1'b1;
               cmd.idx_dec = 1'b1;
               state_in    = S_INS_RD;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_key  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_FIN;
            end
         end
         S_RM_RD: begin
            if (stat.rm_more) begin
               cmd.rd_sel = RD_NEXT;
               state_in   = S_RM_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FIN;
            end
         end
         S_RM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = S_RM_RD;
         end
         S_SR_PROBE: begin
            if (stat.probe_done) begin
               state_in = S_FIN;
            end else begin
               cmd.rd_sel     = RD_MID;
               cmd.srch_probe = 1'b1;
               state_in       = S_SR_CHK;
            end
         end
         S_SR_CHK: begin
            if (stat.rd_eq_key) begin
               cmd.hit  = 1'b1;
               state_in = S_FIN;
            end else begin
               cmd.srch_left  = stat.rd_gt_key;
               cmd.srch_right = ~stat.rd_gt_key;
               state_in       = S_SR_PROBE;
            end
         end
         S_FIN: begin
            state_in = S_FIN2;
         end
         S_FIN2: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### hdl/sorted_table_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_engine
// Sorted key table with insert, remove min/max, binary search and clear.
// Each moved key or search probe is read from the key store in a read state
// (S_INS_RD, S_RM_RD or S_SR_PROBE) and then written back or compared.
// One request in flight; the next is taken the cycle after its result is
// registered, and the result waits while the previous word is still stalled.
// Synchronous reset empties the table and drops any pending word.
// ----------------------------------------------------------------------------
module sorted_table_engine
   import ste_pkg::*;
#(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic [ACTION_W-1:0]     req_action,
   input  wire logic [KEY_PORT_W-1:0]   req_key,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic [STATUS_W-1:0]     rsp_status,
   output      logic                    rsp_found,
   output      logic [INDEX_PORT_W-1:0] rsp_found_index,
   output      logic [COUNT_PORT_W-1:0] rsp_count,
   output      logic [KEY_PORT_W-1:0]   rsp_min_key,
   output      logic [KEY_PORT_W-1:0]   rsp_max_key,
   output      logic                    rsp_is_empty
);

   ste_cmd_type  cmd;
   ste_stat_type stat;

   ste_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   ste_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_key         (req_key),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count),
      .rsp_min_key     (rsp_min_key),
      .rsp_max_key     (rsp_max_key),
      .rsp_is_empty    (rsp_is_empty)
   );

   // ordering of the reported ends
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty || (rsp_min_key <= rsp_max_key)))
      else $error("min key above max key");

   // only a completed search can report a hit
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DONE)) |-> !rsp_found)
      else $error("hit reported with a failing status");

   // a dropped insert leaves the table full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |->
         (rsp_count == COUNT_PORT_W'(CAPACITY)) && !rsp_is_empty)
      else $error("full status with table not full");

   // no new request while a word is still owed
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while busy");

endmodule
`default_nettype wire

### tb/tb_sorted_table_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sorted_table_engine
// Self-checking bench for the sorted table engine. A short table of directed
// requests covers the empty and spare-code cases and the key extremes.
// Random episodes then fill, drain and churn the table, with random gaps and
// stalls on both channels. Every result word is compared field by field with
// the reply typed into its directed row, else one from the bench's table copy.
// ----------------------------------------------------------------------------
module tb_sorted_table_engine;
   import ste_pkg::*;

   localparam int CAPACITY      = DEF_CAPACITY;
   localparam int ITEMS_TOTAL   = 1850;
   localparam int DIRECTED_ROWS = 25;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 80;

   // action codes the block treats as no operation
   localparam logic [ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    found;
      logic [INDEX_PORT_W-1:0] found_index;
      logic [COUNT_PORT_W-1:0] count;
      logic [KEY_PORT_W-1:0]   min_key;
      logic [KEY_PORT_W-1:0]   max_key;
      logic                    is_empty;
   } table_reply_type;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [KEY_PORT_W-1:0] key;
      logic                  typed;
      table_reply_type       reply;
   } directed_row_type;

   localparam table_reply_type NO_REPLY     = '0;
   localparam table_reply_type REPLY_EMPTY  =
      '{ST_DONE, 1'b0, 5'd0, 6'd0, 32'd0, 32'd0, 1'b1};
   localparam table_reply_type REPLY_IGNORE =
      '{ST_EMPTY, 1'b0, 5'd0, 6'd0, 32'd0, 32'd0, 1'b1};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [ACTION_W-1:0]     req_action = ACT_INSERT;
   logic [KEY_PORT_W-1:0]   req_key = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_found;
   logic [INDEX_PORT_W-1:0] rsp_found_index;
   logic [COUNT_PORT_W-1:0] rsp_count;
   logic [KEY_PORT_W-1:0]   rsp_min_key;
   logic [KEY_PORT_W-1:0]   rsp_max_key;
   logic                    rsp_is_empty;

   // bench copy of the table
   logic [KEY_PORT_W-1:0] keys_model [CAPACITY];
   int                    keys_held;

   table_reply_type  replies_due [$];
   table_reply_type  reply_want;
   directed_row_type directed_rows [DIRECTED_ROWS];

   int  mismatches = 0;
   int  idle_cycles = 0;
   int  accepted_items = 0;
   int  holds_asked = 0;
   int  holds_seen = 0;
   int  drain_pauses = 0;
   int  deepest = 0;
   int  per_action [8];
   int  full_drops = 0;
   int  empty_ignores = 0;
   int  search_hits = 0;
   bit  quiet_phase = 1'b0;

   sorted_table_engine i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count),
      .rsp_min_key     (rsp_min_key),
      .rsp_max_key     (rsp_max_key),
      .rsp_is_empty    (rsp_is_empty)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // spread the spare codes over the top of the roll
   function automatic logic [ACTION_W-1:0] ACT_ACTION_SPARE(input int roll);
      if (roll < 95) return ACT_SPARE_5;
      if (roll < 97) return ACT_SPARE_6;
      return ACT_SPARE_7;
   endfunction

   task automatic report_mismatch(input string what, input logic [KEY_PORT_W-1:0] got,
                                  input logic [KEY_PORT_W-1:0] want);
      mismatches++;
      $display("mismatch on %s: got %h, want %h", what, got, want);
   endtask

   // applies one request to the bench table and works out the result word
   task automatic table_after_request(input logic [ACTION_W-1:0] act,
                                      input logic [KEY_PORT_W-1:0] k,
                                      output table_reply_type r);
      int slot;
      int lo;
      int hi;
      int mid;
      r = '0;
      r.status = ST_DONE;
      case (act)
         ACT_INSERT: begin
            if (keys_held >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               // equal keys stay in front of the new one
               slot = keys_held;
               while (slot > 0 && keys_model[slot-1] > k) begin
                  keys_model[slot] = keys_model[slot-1];
                  slot--;
               end
               keys_model[slot] = k;
               keys_held++;
            end
         end
         ACT_REM_MIN: begin
            if (keys_held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               for (slot = 0; slot + 1 < keys_held; slot++)
                  keys_model[slot] = keys_model[slot+1];
               keys_held--;
            end
         end
         ACT_REM_MAX: begin
            if (keys_held == 0) r.status = ST_EMPTY;
            else keys_held--;
         end
         ACT_SEARCH: begin
            // lower midpoint, first matching probe wins
            lo = 0;
            hi = keys_held - 1;
            while (hi >= lo) begin
               mid = lo + (hi - lo) / 2;
               if (keys_model[mid] == k) begin
                  r.found = 1'b1;
                  r.found_index = mid[INDEX_PORT_W-1:0];
                  break;
               end
               if (keys_model[mid] > k) hi = mid - 1;
               else lo = mid + 1;
            end
         end
         ACT_CLEAR: begin
            keys_held = 0;
         end
         default: begin
         end
      endcase
      r.count = keys_held[COUNT_PORT_W-1:0];
      if (keys_held == 0) begin
         r.is_empty = 1'b1;
      end else begin
         r.min_key = keys_model[0];
         r.max_key = keys_model[keys_held-1];
      end
   endtask

   // offers one word and returns at the edge that takes it
   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [KEY_PORT_W-1:0] k,
                               input logic typed, input table_reply_type typed_reply);
      int gap;
      table_reply_type predicted;
      gap = quiet_phase ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= k;
      do @(posedge clock); while (!(req_valid && !req_stall));
      table_after_request(act, k, predicted);
      replies_due.push_back(typed ? typed_reply : predicted);
      accepted_items++;
      per_action[act]++;
      if (predicted.status == ST_FULL) full_drops++;
      if (predicted.status == ST_EMPTY) empty_ignores++;
      if (predicted.found) search_hits++;
      if (keys_held > deepest) deepest = keys_held;
   endtask

   function automatic logic [KEY_PORT_W-1:0] pick_key(input int style,
                                                      input logic [KEY_PORT_W-1:0] base);
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 15);
         2: begin
            case ($urandom_range(0, 5))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'h7FFF_FFFF;
               3: return 32'h8000_0000;
               4: return 32'hFFFF_FFFE;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return base + $urandom_range(0, 63);
      endcase
   endfunction

   // receiver: short random stalls, and a long hold-off when asked for one
   initial begin : receiver
      int stall_len;
      forever begin
         @(posedge clock);
         if (holds_seen != holds_asked) begin
            holds_seen = holds_asked;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            stall_len = quiet_phase ? 0 : pick_gap();
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            report_mismatch("word with nothing expected (count)", 32'(rsp_count), 32'd0);
         end else begin
            reply_want = replies_due.pop_front();
            if (rsp_status !== reply_want.status)
               report_mismatch("status", 32'(rsp_status), 32'(reply_want.status));
            if (rsp_found !== reply_want.found)
               report_mismatch("found", 32'(rsp_found), 32'(reply_want.found));
            if (rsp_found_index !== reply_want.found_index)
               report_mismatch("found_index", 32'(rsp_found_index),
                               32'(reply_want.found_index));
            if (rsp_count !== reply_want.count)
               report_mismatch("count", 32'(rsp_count), 32'(reply_want.count));
            if (rsp_min_key !== reply_want.min_key)
               report_mismatch("min_key", rsp_min_key, reply_want.min_key);
            if (rsp_max_key !== reply_want.max_key)
               report_mismatch("max_key", rsp_max_key, reply_want.max_key);
            if (rsp_is_empty !== reply_want.is_empty)
               report_mismatch("is_empty", 32'(rsp_is_empty), 32'(reply_want.is_empty));
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d replies outstanding", idle_cycles,
                  replies_due.size());
         $display("FAIL sorted_table_engine");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int episode_kind;
      int ep_len;
      int key_style;
      int roll;
      int n;
      logic [ACTION_W-1:0]   act;
      logic [KEY_PORT_W-1:0] k;
      logic [KEY_PORT_W-1:0] key_base;

      keys_held = 0;
      foreach (keys_model[i]) keys_model[i] = '0;
      foreach (per_action[i]) per_action[i] = 0;

      directed_rows = '{
         '{ACT_REM_MIN, 32'h0000_0000, 1'b1, REPLY_IGNORE},
         '{ACT_REM_MAX, 32'hFFFF_FFFF, 1'b1, REPLY_IGNORE},
         '{ACT_SEARCH,  32'h0000_0000, 1'b1, REPLY_EMPTY},
         '{ACT_CLEAR,   32'h0000_0000, 1'b1, REPLY_EMPTY},
         '{ACT_SPARE_5, 32'h1234_5678, 1'b1, REPLY_EMPTY},
         '{ACT_SPARE_6, 32'hFFFF_FFFF, 1'b1, REPLY_EMPTY},
         '{ACT_SPARE_7, 32'h0000_0000, 1'b1, REPLY_EMPTY},
         '{ACT_INSERT,  32'h0000_0000, 1'b1,
           '{ST_DONE, 1'b0, 5'd0, 6'd1, 32'h0000_0000, 32'h0000_0000, 1'b0}},
         '{ACT_INSERT,  32'hFFFF_FFFF, 1'b1,
           '{ST_DONE, 1'b0, 5'd0, 6'd2, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0}},
         '{ACT_SEARCH,  32'hFFFF_FFFF, 1'b0, NO_REPLY},
         '{ACT_SEARCH,  32'h0000_0000, 1'b0, NO_REPLY},
         '{ACT_INSERT,  32'h0000_0005, 1'b0, NO_REPLY},
         '{ACT_INSERT,  32'h0000_0005, 1'b0, NO_REPLY},
         '{ACT_INSERT,  32'h0000_0005, 1'b0, NO_REPLY},
         '{ACT_SEARCH,  32'h0000_0005, 1'b0, NO_REPLY},
         '{ACT_SEARCH,  32'h0000_0006, 1'b0, NO_REPLY},
         '{ACT_SEARCH,  32'h0000_0004, 1'b0, NO_REPLY},
         '{ACT_SPARE_6, 32'hA5A5_5A5A, 1'b0, NO_REPLY},
         '{ACT_REM_MAX, 32'h0000_0000, 1'b0, NO_REPLY},
         '{ACT_REM_MIN, 32'h0000_0000, 1'b0, NO_REPLY},
         '{ACT_INSERT,  32'h8000_0000, 1'b0, NO_REPLY},
         '{ACT_CLEAR,   32'hFFFF_FFFF, 1'b1, REPLY_EMPTY},
         '{ACT_CLEAR,   32'h0000_0000, 1'b1, REPLY_EMPTY},
         '{ACT_INSERT,  32'h7FFF_FFFF, 1'b1,
           '{ST_DONE, 1'b0, 5'd0, 6'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0}},
         '{ACT_REM_MIN, 32'h0000_0000, 1'b1, REPLY_EMPTY}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].action, directed_rows[i].key, directed_rows[i].typed,
                      directed_rows[i].reply);

      while (accepted_items < ITEMS_TOTAL) begin
         episode_kind = $urandom_range(0, 3);
         key_style    = $urandom_range(0, 3);
         key_base     = $urandom;
         quiet_phase  = ($urandom_range(0, 5) == 0);
         ep_len       = $urandom_range(20, 90);
         for (n = 0; n < ep_len && accepted_items < ITEMS_TOTAL; n++) begin
            roll = $urandom_range(0, 99);
            case (episode_kind)
               // fill: mostly inserts, so full tables and dropped inserts turn up
               0: act = (roll < 75) ? ACT_INSERT : (roll < 88) ? ACT_SEARCH :
                        (roll < 94) ? ACT_REM_MIN : (roll < 97) ? ACT_REM_MAX : ACT_SPARE_5;
               // drain: mostly removals, running past empty now and then
               1: act = (roll < 35) ? ACT_REM_MIN : (roll < 70) ? ACT_REM_MAX :
                        (roll < 88) ? ACT_SEARCH : (roll < 97) ? ACT_INSERT : ACT_SPARE_7;
               default: act = (roll < 35) ? ACT_INSERT : (roll < 47) ? ACT_REM_MIN :
                              (roll < 59) ? ACT_REM_MAX : (roll < 89) ? ACT_SEARCH :
                              (roll < 93) ? ACT_CLEAR :
                              ACT_ACTION_SPARE(roll);
            endcase
            if (act == ACT_SEARCH && keys_held > 0 && $urandom_range(0, 2) != 0)
               k = keys_model[$urandom_range(0, keys_held - 1)];
            else if (act == ACT_INSERT || act == ACT_SEARCH)
               k = pick_key(key_style, key_base);
            else
               k = $urandom;
            send_request(act, k, 1'b0, NO_REPLY);

            if (accepted_items == 400 || accepted_items == 1300)
               holds_asked++;
            if (accepted_items == 800 || accepted_items == 1550) begin
               // sender waits for every outstanding word before going on
               req_valid <= 1'b0;
               while (replies_due.size() != 0) @(posedge clock);
               repeat ($urandom_range(5, 30)) @(posedge clock);
               drain_pauses++;
            end
         end
      end
      req_valid <= 1'b0;
      quiet_phase = 1'b0;

      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d inserts (%0d dropped), %0d removals (%0d on empty)",
               accepted_items, per_action[ACT_INSERT], full_drops,
               per_action[ACT_REM_MIN] + per_action[ACT_REM_MAX], empty_ignores);
      $display("%0d searches (%0d hits), %0d clears, %0d spare codes, depth up to %0d of %0d",
               per_action[ACT_SEARCH], search_hits, per_action[ACT_CLEAR],
               per_action[ACT_SPARE_5] + per_action[ACT_SPARE_6] + per_action[ACT_SPARE_7],
               deepest, CAPACITY);
      if (mismatches == 0) begin
         $display("PASS sorted_table_engine");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL sorted_table_engine");
      end
      $finish;
   end

endmodule
`default_nettype wire
